// ===== src/igcmd5_pkg.sv =====
// Shared constants and functions for the record signer: MD5 round tables and initial vectors.
// Used by igcmd5_core and igc_record_md5_signer. No dependencies.
package igcmd5_pkg;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] PAD_BYTE   = 8'h80;

  function automatic logic [31:0] init_word(input logic [3:0] i);
    logic [31:0] r;
    case (i)
      4'd0:  r = 32'h63e54c01;
      4'd1:  r = 32'h25adab89;
      4'd2:  r = 32'h44baecfe;
      4'd3:  r = 32'h60f25476;
      4'd4:  r = 32'h41e24d03;
      4'd5:  r = 32'h23b8ebea;
      4'd6:  r = 32'h4a4bfc9e;
      4'd7:  r = 32'h640ed89a;
      4'd8:  r = 32'h61e54e01;
      4'd9:  r = 32'h22cdab89;
      4'd10: r = 32'h48b20cfe;
      4'd11: r = 32'h62125476;
      4'd12: r = 32'hc1e84fe8;
      4'd13: r = 32'h21d1c28a;
      4'd14: r = 32'h438e1a12;
      default: r = 32'h6c250aee;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] r;
    case (i)
      6'd0: r=32'hd76aa478; 6'd1: r=32'he8c7b756; 6'd2: r=32'h242070db; 6'd3: r=32'hc1bdceee;
      6'd4: r=32'hf57c0faf; 6'd5: r=32'h4787c62a; 6'd6: r=32'ha8304613; 6'd7: r=32'hfd469501;
      6'd8: r=32'h698098d8; 6'd9: r=32'h8b44f7af; 6'd10: r=32'hffff5bb1; 6'd11: r=32'h895cd7be;
      6'd12: r=32'h6b901122; 6'd13: r=32'hfd987193; 6'd14: r=32'ha679438e; 6'd15: r=32'h49b40821;
      6'd16: r=32'hf61e2562; 6'd17: r=32'hc040b340; 6'd18: r=32'h265e5a51; 6'd19: r=32'he9b6c7aa;
      6'd20: r=32'hd62f105d; 6'd21: r=32'h02441453; 6'd22: r=32'hd8a1e681; 6'd23: r=32'he7d3fbc8;
      6'd24: r=32'h21e1cde6; 6'd25: r=32'hc33707d6; 6'd26: r=32'hf4d50d87; 6'd27: r=32'h455a14ed;
      6'd28: r=32'ha9e3e905; 6'd29: r=32'hfcefa3f8; 6'd30: r=32'h676f02d9; 6'd31: r=32'h8d2a4c8a;
      6'd32: r=32'hfffa3942; 6'd33: r=32'h8771f681; 6'd34: r=32'h6d9d6122; 6'd35: r=32'hfde5380c;
      6'd36: r=32'ha4beea44; 6'd37: r=32'h4bdecfa9; 6'd38: r=32'hf6bb4b60; 6'd39: r=32'hbebfbc70;
      6'd40: r=32'h289b7ec6; 6'd41: r=32'heaa127fa; 6'd42: r=32'hd4ef3085; 6'd43: r=32'h04881d05;
      6'd44: r=32'hd9d4d039; 6'd45: r=32'he6db99e5; 6'd46: r=32'h1fa27cf8; 6'd47: r=32'hc4ac5665;
      6'd48: r=32'hf4292244; 6'd49: r=32'h432aff97; 6'd50: r=32'hab9423f7; 6'd51: r=32'hfc93ab39;
      6'd52: r=32'h655b59c3; 6'd53: r=32'h8f0ccc92; 6'd54: r=32'hffeff47d; 6'd55: r=32'h85845dd1;
      6'd56: r=32'h6fa87e4f; 6'd57: r=32'hfe2ce6e0; 6'd58: r=32'ha3014314; 6'd59: r=32'h4e0811a1;
      6'd60: r=32'hf7537e82; 6'd61: r=32'hbd3af235; 6'd62: r=32'h2ad7d2bb; default: r=32'heb86d391;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [3:0] i);
    logic [4:0] r;
    case (i)
      4'd0: r=5'd7;  4'd1: r=5'd12; 4'd2: r=5'd17; 4'd3: r=5'd22;
      4'd4: r=5'd5;  4'd5: r=5'd9;  4'd6: r=5'd14; 4'd7: r=5'd20;
      4'd8: r=5'd4;  4'd9: r=5'd11; 4'd10: r=5'd16; 4'd11: r=5'd23;
      4'd12: r=5'd6; 4'd13: r=5'd10; 4'd14: r=5'd15; default: r=5'd21;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] msg_index(input logic [5:0] i);
    logic [3:0] r;
    case (i[5:4])
      2'd0: r = i[3:0];
      2'd1: r = 4'(5 * i[3:0] + 1);
      2'd2: r = 4'(3 * i[3:0] + 5);
      default: r = 4'(7 * i[3:0]);
    endcase
    return r;
  endfunction

  function automatic logic [7:0] clean_byte(input logic [7:0] x);
    logic bad;
    bad = (x < 8'h20) || (x > 8'h7D) || (x == 8'h24) || (x == 8'h2A) || (x == 8'h2C) ||
          (x == 8'h21) || (x == 8'h5C) || (x == 8'h5E);
    return bad ? CHAR_SPACE : x;
  endfunction

  function automatic logic [31:0] bswap32(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

// ===== src/igcmd5_core.sv =====
// MD5 compression unit: one round per cycle over a message block held in a word memory.
// Depends on igcmd5_pkg. The caller owns the block memory and answers word reads.
module igcmd5_core
  import igcmd5_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [127:0] h_in,
  output logic [3:0]   w_addr,
  input  logic [31:0]  w_data,
  output logic         done,
  output logic [127:0] h_out
);

  typedef enum logic [1:0] {C_IDLE, C_FETCH, C_RUN, C_ADD} cstate_t;

  cstate_t     state_r;
  logic [5:0]  rnd_r;
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [127:0] h_r;
  logic [31:0] f, s, rot;
  logic [4:0]  sh;
  logic [5:0]  rnd_next;

  assign rnd_next = rnd_r + 6'd1;
  assign w_addr = (state_r == C_RUN) ? msg_index(rnd_next) : msg_index(6'd0);

  always_comb begin
    case (rnd_r[5:4])
      2'd0: f = (b_r & c_r) | (~b_r & d_r);
      2'd1: f = (d_r & b_r) | (~d_r & c_r);
      2'd2: f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
    s   = f + a_r + round_k(rnd_r) + w_data;
    sh  = rot_amount({rnd_r[5:4], rnd_r[1:0]});
    rot = (s << sh) | (s >> (6'd32 - {1'b0, sh}));
  end

  assign h_out = {h_r[127:96] + a_r, h_r[95:64] + b_r, h_r[63:32] + c_r, h_r[31:0] + d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state_r)
        C_IDLE: begin
          if (start) begin
            h_r <= h_in;
            a_r <= h_in[127:96];
            b_r <= h_in[95:64];
            c_r <= h_in[63:32];
            d_r <= h_in[31:0];
            rnd_r <= 6'd0;
            state_r <= C_FETCH;
          end
        end
        C_FETCH: state_r <= C_RUN;
        C_RUN: begin
          a_r <= d_r;
          d_r <= c_r;
          c_r <= b_r;
          b_r <= b_r + rot;
          rnd_r <= rnd_next;
          if (rnd_r == 6'd63) begin
            state_r <= C_ADD;
          end
        end
        C_ADD: begin
          done    <= 1'b1;
          state_r <= C_IDLE;
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

endmodule

// ===== src/igc_record_md5_signer.sv =====
// Top level of the record signer: byte cleaning, block memory, chaining memory, finalization.
// Depends on igcmd5_pkg and igcmd5_core.
//
//  channel | ports                                   | handshake
//  in      | in_data_byte, in_record_end             | in_valid / in_stall
//  out     | out_result_kind .. out_run_last         | out_valid / out_stall
//  cfg     | cfg_sign_enable                         | cfg_valid / cfg_ready
//
// A byte that causes no compression passes through S_IDLE and S_ECHO. A byte that fills a block
// runs one compression per context in the one round-per-cycle MD5 unit; each digest costs
// one or two such compressions over the block memory, with padding and length substituted.
// Reset is synchronous; chaining words reload from the initial vectors as they are read.
// Out_stall holds the result register and the sequencer waits on it.
module igc_record_md5_signer
  import igcmd5_pkg::*;
#(
  parameter int NUM_CONTEXTS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_record_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [7:0]  out_char,
  output logic [1:0]  out_context_index,
  output logic [63:0] out_digest_upper,
  output logic [63:0] out_digest_lower,
  output logic        out_run_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_sign_enable
);

  typedef enum logic [3:0] {
    S_IDLE, S_ECHO, S_CMP_RD, S_CMP_WAIT, S_CMP_RUN, S_FIN_RD, S_FIN_WAIT,
    S_FIN_RUN, S_FIN_OUT, S_NEXT
  } state_t;

  state_t      state_r;
  logic        sign_en_r;
  logic [3:0]  iv_done_r;
  logic [63:0] bitcnt_r;
  logic [7:0]  char_r;
  logic        last_r;
  logic [1:0]  ctx_r;
  logic        second_r;
  logic [127:0] hcopy_r;

  logic [31:0] blk_mem [16];
  logic [31:0] word_q;
  logic [127:0] chain_mem [4];
  logic [127:0] chain_q;
  logic [127:0] chain_eff;

  logic        core_start, core_done;
  logic [3:0]  core_waddr;
  logic [3:0]  core_waddr_q;
  logic [31:0] core_wdata;
  logic [127:0] core_hin, core_hout;

  logic [5:0]  fill;
  logic        fin_mode;
  logic        two_blocks;
  logic        out_load;

  assign fill       = bitcnt_r[8:3];
  assign in_stall   = (state_r != S_IDLE);
  assign cfg_ready  = (state_r == S_IDLE) && !in_valid;
  assign two_blocks = (fill > 6'd55);
  assign out_load   = ((state_r == S_ECHO) || (state_r == S_FIN_OUT)) &&
                      (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    chain_q <= chain_mem[ctx_r];
    word_q  <= blk_mem[core_waddr];
  end

  assign chain_eff = iv_done_r[ctx_r] ? chain_q :
                     {init_word({ctx_r, 2'd0}), init_word({ctx_r, 2'd1}),
                      init_word({ctx_r, 2'd2}), init_word({ctx_r, 2'd3})};

  function automatic logic [7:0] fin_byte(input logic [5:0] p, input logic [7:0] mb,
                                          input logic [5:0] f, input logic two,
                                          input logic sec, input logic [63:0] cnt);
    logic [7:0] r;
    logic       lenb;
    lenb = (p >= 6'd56) && (!two || sec);
    if (sec) begin
      r = 8'h00;
    end else if (p < f) begin
      r = mb;
    end else if (p == f) begin
      r = PAD_BYTE;
    end else begin
      r = 8'h00;
    end
    if (lenb) begin
      r = cnt[8 * p[2:0] +: 8];
    end
    return r;
  endfunction

  assign fin_mode = (state_r == S_FIN_RUN);
  always_comb begin
    core_wdata = word_q;
    if (fin_mode) begin
      core_wdata = {fin_byte({core_waddr_q, 2'd3}, word_q[31:24], fill, two_blocks, second_r,
                             bitcnt_r),
                    fin_byte({core_waddr_q, 2'd2}, word_q[23:16], fill, two_blocks, second_r,
                             bitcnt_r),
                    fin_byte({core_waddr_q, 2'd1}, word_q[15:8], fill, two_blocks, second_r,
                             bitcnt_r),
                    fin_byte({core_waddr_q, 2'd0}, word_q[7:0], fill, two_blocks, second_r,
                             bitcnt_r)};
    end
  end

  always_ff @(posedge clk) begin
    core_waddr_q <= core_waddr;
  end

  assign core_start = (state_r == S_CMP_WAIT) || (state_r == S_FIN_WAIT);
  assign core_hin   = (state_r == S_FIN_WAIT && second_r) ? hcopy_r : chain_eff;

  igcmd5_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (core_start),
    .h_in   (core_hin),
    .w_addr (core_waddr),
    .w_data (core_wdata),
    .done   (core_done),
    .h_out  (core_hout)
  );

  function automatic logic [63:0] pack_words(input logic [31:0] w0, input logic [31:0] w1);
    return {bswap32(w0), bswap32(w1)};
  endfunction

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid && sign_en_r && in_data_byte != CHAR_CR &&
        in_data_byte != CHAR_LF) begin
      blk_mem[fill[5:2]][8 * fill[1:0] +: 8] <= clean_byte(in_data_byte);
    end
    if (state_r == S_CMP_RUN && core_done) begin
      chain_mem[ctx_r] <= core_hout;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      sign_en_r <= 1'b1;
      iv_done_r <= '0;
      bitcnt_r  <= '0;
      out_valid <= 1'b0;
      ctx_r     <= '0;
      second_r  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        sign_en_r <= cfg_sign_enable;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            last_r <= in_record_end && sign_en_r;
            ctx_r  <= '0;
            if (in_data_byte == CHAR_CR || in_data_byte == CHAR_LF) begin
              char_r <= in_data_byte;
            end else begin
              char_r <= clean_byte(in_data_byte);
              if (sign_en_r) begin
                bitcnt_r <= bitcnt_r + 64'd8;
              end
            end
            state_r <= S_ECHO;
          end
        end
        S_ECHO: begin
          if (out_load) begin
            out_result_kind   <= 1'b0;
            out_char          <= char_r;
            out_context_index <= '0;
            out_digest_upper  <= '0;
            out_digest_lower  <= '0;
            out_run_last      <= !last_r;
            if (char_r != CHAR_CR && char_r != CHAR_LF && sign_en_r && fill == 6'd0 &&
                bitcnt_r != 64'd0) begin
              state_r <= S_CMP_RD;
            end else if (last_r) begin
              state_r <= S_FIN_RD;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_CMP_RD: state_r <= S_CMP_WAIT;
        S_CMP_WAIT: state_r <= S_CMP_RUN;
        S_CMP_RUN: begin
          if (core_done) begin
            iv_done_r[ctx_r] <= 1'b1;
            if (32'(ctx_r) == NUM_CONTEXTS - 1) begin
              ctx_r   <= '0;
              state_r <= last_r ? S_FIN_RD : S_IDLE;
            end else begin
              ctx_r   <= ctx_r + 2'd1;
              state_r <= S_CMP_RD;
            end
          end
        end
        S_FIN_RD: state_r <= S_FIN_WAIT;
        S_FIN_WAIT: state_r <= S_FIN_RUN;
        S_FIN_RUN: begin
          if (core_done) begin
            hcopy_r <= core_hout;
            if (two_blocks && !second_r) begin
              second_r <= 1'b1;
              state_r  <= S_FIN_WAIT;
            end else begin
              second_r <= 1'b0;
              state_r  <= S_FIN_OUT;
            end
          end
        end
        S_FIN_OUT: begin
          if (out_load) begin
            out_result_kind   <= 1'b1;
            out_char          <= '0;
            out_context_index <= ctx_r;
            out_digest_upper  <= pack_words(hcopy_r[127:96], hcopy_r[95:64]);
            out_digest_lower  <= pack_words(hcopy_r[63:32], hcopy_r[31:0]);
            out_run_last      <= (32'(ctx_r) == NUM_CONTEXTS - 1);
            state_r           <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (32'(ctx_r) == NUM_CONTEXTS - 1) begin
            state_r <= S_IDLE;
          end else begin
            ctx_r   <= ctx_r + 2'd1;
            state_r <= S_FIN_RD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== dv/igc_record_md5_signer_tb.sv =====
// Self-checking testbench for igc_record_md5_signer: drives record bytes, predicts echoes
// and four MD5 digests per signed record end, and compares every result field by field.
// Depends on igcmd5_pkg and the igc_record_md5_signer RTL.
module igc_record_md5_signer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import igcmd5_pkg::*;

  localparam int NCTX = 4;
  localparam logic KIND_ECHO = 1'b0;
  localparam logic KIND_DIGEST = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       record_end;
  } rec_byte_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  ch;
    logic [1:0]  ctx;
    logic [63:0] upper;
    logic [63:0] lower;
    logic        last;
  } signer_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_data_byte = '0;
  logic in_record_end = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_result_kind;
  logic [7:0] out_char;
  logic [1:0] out_context_index;
  logic [63:0] out_digest_upper;
  logic [63:0] out_digest_lower;
  logic out_run_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_sign_enable = 1'b0;

  igc_record_md5_signer #(.NUM_CONTEXTS(NCTX)) dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  rec_byte_t pending_bytes[$];
  signer_result_t expected_results[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Predictor state.
  logic        sign_on;
  logic [31:0] chain[16];
  logic [7:0]  blk[64];
  logic [63:0] bit_count;

  function automatic logic [31:0] rotl(logic [31:0] x, int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  task automatic md5_compress(inout logic [31:0] h[4], input logic [7:0] b[64]);
    logic [31:0] w[16];
    logic [31:0] a, bb, c, d, f;
    int g;
    int rs[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    for (int i = 0; i < 16; i++)
      w[i] = {b[4*i+3], b[4*i+2], b[4*i+1], b[4*i]};
    a = h[0]; bb = h[1]; c = h[2]; d = h[3];
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin f = (bb & c) | (~bb & d); g = i; end
        1: begin f = (d & bb) | (~d & c); g = (5 * i + 1) % 16; end
        2: begin f = bb ^ c ^ d; g = (3 * i + 5) % 16; end
        default: begin f = c ^ (bb | ~d); g = (7 * i) % 16; end
      endcase
      f = f + a + round_k(6'(i)) + w[g];
      a = d; d = c; c = bb;
      bb = bb + rotl(f, rs[(i / 16) * 4 + i % 4]);
    end
    h[0] += a; h[1] += bb; h[2] += c; h[3] += d;
  endtask

  function automatic logic [7:0] sanitize(logic [7:0] x);
    if (x < 8'h20 || x > 8'h7D || x == 8'h24 || x == 8'h2A || x == 8'h2C ||
        x == 8'h21 || x == 8'h5C || x == 8'h5E) return 8'h20;
    return x;
  endfunction

  function automatic logic [63:0] pack_le(logic [31:0] w0, logic [31:0] w1);
    return {w0[7:0], w0[15:8], w0[23:16], w0[31:24], w1[7:0], w1[15:8], w1[23:16], w1[31:24]};
  endfunction

  task automatic predict_signer(input rec_byte_t item);
    signer_result_t r;
    logic [31:0] h[4];
    logic [7:0] buf_b[64];
    logic [7:0] ch;
    int idx;
    logic digests;
    digests = item.record_end && sign_on;
    if (item.data_byte == CHAR_CR || item.data_byte == CHAR_LF) begin
      ch = item.data_byte;
    end else begin
      ch = sanitize(item.data_byte);
      if (sign_on) begin
        idx = int'(bit_count[8:3]);
        blk[idx] = ch;
        bit_count += 64'd8;
        if (idx == 63) begin
          for (int k = 0; k < NCTX; k++) begin
            for (int j = 0; j < 4; j++) h[j] = chain[4*k+j];
            md5_compress(h, blk);
            for (int j = 0; j < 4; j++) chain[4*k+j] = h[j];
          end
        end
      end
    end
    r = '0;
    r.kind = KIND_ECHO;
    r.ch = ch;
    r.last = !digests;
    expected_results.push_back(r);
    if (digests) begin
      for (int k = 0; k < NCTX; k++) begin
        for (int j = 0; j < 4; j++) h[j] = chain[4*k+j];
        buf_b = blk;
        idx = int'(bit_count[8:3]);
        buf_b[idx] = PAD_BYTE;
        idx++;
        if (idx > 56) begin
          for (int i = idx; i < 64; i++) buf_b[i] = 8'h00;
          md5_compress(h, buf_b);
          idx = 0;
        end
        for (int i = idx; i < 56; i++) buf_b[i] = 8'h00;
        for (int i = 0; i < 8; i++) buf_b[56+i] = bit_count[8*i +: 8];
        md5_compress(h, buf_b);
        r = '0;
        r.kind = KIND_DIGEST;
        r.ctx = 2'(k);
        r.upper = pack_le(h[0], h[1]);
        r.lower = pack_le(h[2], h[3]);
        r.last = (k == NCTX - 1);
        expected_results.push_back(r);
      end
    end
  endtask

  // Driver.
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || !in_stall) begin
        if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          rec_byte_t it;
          it = pending_bytes.pop_front();
          predict_signer(it);
          in_valid <= 1'b1;
          in_data_byte <= it.data_byte;
          in_record_end <= it.record_end;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      signer_result_t got, exp_r;
      got = '{out_result_kind, out_char, out_context_index, out_digest_upper,
              out_digest_lower, out_run_last};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got.kind !== exp_r.kind) begin
          $display("%0t: kind exp %h got %h", $time, exp_r.kind, got.kind); errors++;
        end
        if (got.ch !== exp_r.ch) begin
          $display("%0t: char exp %h got %h", $time, exp_r.ch, got.ch); errors++;
        end
        if (got.ctx !== exp_r.ctx) begin
          $display("%0t: context exp %h got %h", $time, exp_r.ctx, got.ctx); errors++;
        end
        if (got.upper !== exp_r.upper) begin
          $display("%0t: digest upper exp %h got %h", $time, exp_r.upper, got.upper); errors++;
        end
        if (got.lower !== exp_r.lower) begin
          $display("%0t: digest lower exp %h got %h", $time, exp_r.lower, got.lower); errors++;
        end
        if (got.last !== exp_r.last) begin
          $display("%0t: run_last exp %h got %h", $time, exp_r.last, got.last); errors++;
        end
      end
    end
  end

  task automatic add_byte(input logic [7:0] b, input logic e);
    pending_bytes.push_back('{b, e});
  endtask

  task automatic drain_all();
    while (pending_bytes.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_sign_enable(input logic v);
    cfg_valid <= 1'b1;
    cfg_sign_enable <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sign_on = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic add_random_records(input int n);
    int cnt, len;
    cnt = 0;
    while (cnt < n) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(70, 140) : $urandom_range(1, 20);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(9))
          0: add_byte(CHAR_CR, i == len - 1);
          1: add_byte(CHAR_LF, i == len - 1);
          2, 3: add_byte(8'($urandom_range(255)), i == len - 1);
          default: add_byte(8'($urandom_range(8'h20, 8'h7F)), i == len - 1);
        endcase
        cnt++;
      end
    end
  endtask

  initial begin
    logic [7:0] rejects[10];
    rejects = '{8'h24, 8'h2A, 8'h2C, 8'h21, 8'h5C, 8'h5E, 8'h1F, 8'h7E, 8'h7D, 8'h20};
    sign_on = 1'b1;
    for (int i = 0; i < 16; i++) chain[i] = init_word(4'(i));
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    bit_count = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 9; recv_idle_pct = 45;
    // Directed: empty-ish record, extremes, NUL, CR/LF, rejected characters and range edges.
    add_byte(8'h41, 1'b1);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(CHAR_CR, 1'b0);
    add_byte(CHAR_LF, 1'b1);
    for (int i = 0; i < 10; i++)
      add_byte(rejects[i], i == 9);
    // Fill past the 56-byte boundary so padding spills into a second block.
    for (int i = 0; i < 44; i++) add_byte(8'h55 + 8'(i % 3), i == 43);
    drain_all();

    write_sign_enable(1'b0);
    add_byte(8'h42, 1'b0);
    add_byte(8'hAA, 1'b1);
    drain_all();
    write_sign_enable(1'b1);

    add_random_records(100);
    drain_all();
    write_sign_enable(1'b0);
    add_random_records(15);
    drain_all();
    write_sign_enable(1'b1);
    send_idle_pct = 45; recv_idle_pct = 9;
    add_random_records(90);
    drain_all();
    send_idle_pct = 0; recv_idle_pct = 0;
    add_random_records(90);
    drain_all();

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
